[rtl/core/grlc_pkg.sv]
// Gamepad report link controller: shared types and constants.
// No dependencies.
package grlc_pkg;

  localparam int unsigned KeyW    = 10;
  localparam int unsigned ByteW   = 8;

  // Key bit positions in the held-key mask
  localparam int unsigned KeyA      = 0;
  localparam int unsigned KeyB      = 1;
  localparam int unsigned KeySelect = 2;
  localparam int unsigned KeyStart  = 3;
  localparam int unsigned KeyRight  = 4;
  localparam int unsigned KeyLeft   = 5;
  localparam int unsigned KeyUp     = 6;
  localparam int unsigned KeyDown   = 7;
  localparam int unsigned KeyR      = 8;
  localparam int unsigned KeyL      = 9;

  localparam logic [ByteW-1:0] HoldThresholdRst = 8'd150;
  localparam logic [ByteW-1:0] HoldMax          = 8'hFF;
  localparam logic [ByteW-1:0] AxisPos          = 8'h7F;
  localparam logic [ByteW-1:0] AxisNeg          = 8'h80;

  typedef enum logic [1:0] {
    LINK_DISCOVERING = 2'd0,
    LINK_CONNECTING  = 2'd1,
    LINK_CONNECTED   = 2'd2
  } link_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_REPORT     = 3'd1,
    ACT_DISCONNECT = 3'd2,
    ACT_CONNECT    = 3'd3,
    ACT_FAILED     = 3'd4
  } action_e;

  // Packed as x<<24 | y<<16 | face<<8 | system
  typedef struct packed {
    logic [ByteW-1:0] x_axis;
    logic [ByteW-1:0] y_axis;
    logic [ByteW-1:0] face;
    logic [ByteW-1:0] sys;
  } report_t;

  typedef struct packed {
    action_e act;
    report_t rep;
    link_e   link;
  } result_t;

endpackage

[rtl/core/grlc_report_build.sv]
// Maps the held-key mask onto a gamepad report.
// Depends on grlc_pkg.
module grlc_report_build import grlc_pkg::*; (
  input  logic [KeyW-1:0] keys_i,
  output report_t         report_o
);

  always_comb begin
    report_o = '0;
    report_o.face[0] = keys_i[KeyA];
    report_o.face[1] = keys_i[KeyB];
    report_o.face[4] = keys_i[KeyL];
    report_o.face[5] = keys_i[KeyR];
    report_o.sys[4]  = keys_i[KeySelect];
    report_o.sys[5]  = keys_i[KeyStart];
    // down beats up, left beats right
    if (keys_i[KeyDown]) begin
      report_o.y_axis = AxisPos;
    end else if (keys_i[KeyUp]) begin
      report_o.y_axis = AxisNeg;
    end
    if (keys_i[KeyLeft]) begin
      report_o.x_axis = AxisNeg;
    end else if (keys_i[KeyRight]) begin
      report_o.x_axis = AxisPos;
    end
  end

endmodule

[rtl/core/grlc_link_fsm.sv]
// Link state machine, start-hold counter and last-report memory.
// Depends on grlc_pkg and grlc_report_build.
module grlc_link_fsm import grlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [KeyW-1:0]  keys_i,
  input  logic             paired_i,
  input  logic             command_ready_i,
  input  logic [ByteW-1:0] hold_threshold_i,
  output result_t          result_o
);

  link_e            link_q, link_d;
  logic [ByteW-1:0] hold_q, hold_d;
  report_t          last_q, last_d;
  report_t          fresh;
  logic [ByteW-1:0] hold_inc;
  logic             drop;

  grlc_report_build u_build (
    .keys_i   (keys_i),
    .report_o (fresh)
  );

  assign hold_inc = hold_q + 8'd1;

  // next-state block
  always_comb begin
    link_d = link_q;
    hold_d = hold_q;
    last_d = last_q;
    drop   = 1'b0;
    unique case (link_q)
      LINK_DISCOVERING: begin
        if (keys_i[KeyA]) begin
          if (command_ready_i) begin
            link_d = LINK_CONNECTING;
          end
        end else if (paired_i) begin
          link_d = LINK_CONNECTED;
        end
      end
      LINK_CONNECTING: begin
        if (paired_i) begin
          link_d = LINK_CONNECTED;
        end
      end
      LINK_CONNECTED: begin
        if (keys_i[KeyStart]) begin
          if (hold_q != HoldMax) begin
            hold_d = hold_inc;
            drop   = (hold_inc == hold_threshold_i);
          end
        end else begin
          hold_d = '0;
        end
        if (drop) begin
          link_d = LINK_DISCOVERING;
        end else if (fresh != last_q) begin
          last_d = fresh;
        end
      end
      default: begin
      end
    endcase
  end

  // output block
  always_comb begin
    result_o.act  = ACT_NONE;
    result_o.rep  = '0;
    result_o.link = link_d;
    unique case (link_q)
      LINK_DISCOVERING: begin
        if (keys_i[KeyA]) begin
          result_o.act = command_ready_i ? ACT_CONNECT : ACT_FAILED;
        end
      end
      LINK_CONNECTED: begin
        if (drop) begin
          result_o.act = ACT_DISCONNECT;
        end else if (fresh != last_q) begin
          result_o.act = ACT_REPORT;
          result_o.rep = fresh;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LINK_DISCOVERING;
      hold_q <= '0;
      last_q <= '0;
    end else if (fire_i) begin
      link_q <= link_d;
      hold_q <= hold_d;
      last_q <= last_d;
    end
  end

  a_drop_to_discovering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.act == ACT_DISCONNECT |=> link_q == LINK_DISCOVERING)
    else $error("disconnect did not return link to discovering");

  a_report_updates_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.act == ACT_REPORT |=> last_q == $past(result_o.rep))
    else $error("sent report not remembered");

  a_hold_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && link_q == LINK_CONNECTED && !keys_i[KeyStart] |=> hold_q == '0)
    else $error("hold count not cleared on start release");

endmodule

[rtl/core/gamepad_report_link_controller_top.sv]
// Gamepad report link controller, top level: input register, link logic,
// result register and threshold register. Depends on grlc_pkg, grlc_link_fsm.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | sink      | in_valid_i/in_stall_o| keys_i, paired_i, command_ready_i
//  out     | source    | out_valid_o/out_stall_i | action_o, x_axis_o, y_axis_o,
//          |           |                      | face_buttons_o, system_buttons_o,
//          |           |                      | link_state_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_data_i (hold threshold)
//
// One beat in, one beat out. Throughput is one beat per cycle while the
// output is not stalled; a beat goes from input accept through the input
// register, then a single pass through the link logic into the result register.
// The link state only advances when the buffered beat moves into the result
// register, so a stalled output holds the input beat and its effect on state.
// Reset: link discovering, hold count and last report zero, threshold 150.
// cfg_ready_o is tied high; the threshold is written any cycle.
module gamepad_report_link_controller_top import grlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beats
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [KeyW-1:0]  keys_i,
  input  logic             paired_i,
  input  logic             command_ready_i,
  // result beats
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       action_o,
  output logic [ByteW-1:0] x_axis_o,
  output logic [ByteW-1:0] y_axis_o,
  output logic [ByteW-1:0] face_buttons_o,
  output logic [ByteW-1:0] system_buttons_o,
  output logic [1:0]       link_state_o,
  // threshold register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ByteW-1:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  logic [KeyW-1:0]  keys_q;
  logic             paired_q;
  logic             cmd_ready_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q;
  result_t          res_d;
  logic [ByteW-1:0] thr_q;
  logic             fire;
  logic             load;

  // buffered beat moves on when the result slot is free or being drained
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign load       = in_valid_i && !in_stall_o;

  assign in_valid_d  = load || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  assign cfg_ready_o = 1'b1;

  grlc_link_fsm u_link (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .keys_i           (keys_q),
    .paired_i         (paired_q),
    .command_ready_i  (cmd_ready_q),
    .hold_threshold_i (thr_q),
    .result_o         (res_d)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= HoldThresholdRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      keys_q      <= keys_i;
      paired_q    <= paired_i;
      cmd_ready_q <= command_ready_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = res_q.act;
  assign x_axis_o         = res_q.rep.x_axis;
  assign y_axis_o         = res_q.rep.y_axis;
  assign face_buttons_o   = res_q.rep.face;
  assign system_buttons_o = res_q.rep.sys;
  assign link_state_o     = res_q.link;

  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with nothing buffered");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_REPORT |->
      x_axis_o == '0 && y_axis_o == '0 && face_buttons_o == '0 &&
      system_buttons_o == '0)
    else $error("report fields set without a report");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("fired beat lost");

endmodule

[tb/gamepad_report_link_controller_top_tb.sv]
// Self-checking testbench for gamepad_report_link_controller_top: link state,
// report building and start-hold disconnect checked against an in-bench predictor.
// Depends on grlc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module gamepad_report_link_controller_top_tb;
  import grlc_pkg::*;

  // Key masks for building frames by name
  localparam logic [KeyW-1:0] MaskA      = KeyW'(1) << KeyA;
  localparam logic [KeyW-1:0] MaskB      = KeyW'(1) << KeyB;
  localparam logic [KeyW-1:0] MaskSelect = KeyW'(1) << KeySelect;
  localparam logic [KeyW-1:0] MaskStart  = KeyW'(1) << KeyStart;
  localparam logic [KeyW-1:0] MaskRight  = KeyW'(1) << KeyRight;
  localparam logic [KeyW-1:0] MaskLeft   = KeyW'(1) << KeyLeft;
  localparam logic [KeyW-1:0] MaskUp     = KeyW'(1) << KeyUp;
  localparam logic [KeyW-1:0] MaskDown   = KeyW'(1) << KeyDown;
  localparam logic [KeyW-1:0] MaskR      = KeyW'(1) << KeyR;
  localparam logic [KeyW-1:0] MaskL      = KeyW'(1) << KeyL;
  localparam logic [KeyW-1:0] MaskAll    = '1;

  localparam int unsigned LongStallCycles = 300;
  localparam int unsigned RandomFrames    = 1500;
  localparam int unsigned PhaseFrames     = 150;

  // One input beat: a frame tick
  typedef struct packed {
    logic [KeyW-1:0] keys;
    logic            paired;
    logic            cmd_ready;
  } frame_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE     = 2'd0,
    RX_LIGHT    = 2'd1,
    RX_HEAVY    = 2'd2,
    RX_PERIODIC = 2'd3
  } rx_mode_e;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_stall_o;
  logic [KeyW-1:0]  keys_i           = '0;
  logic             paired_i         = 1'b0;
  logic             command_ready_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i      = 1'b0;
  logic [2:0]       action_o;
  logic [ByteW-1:0] x_axis_o;
  logic [ByteW-1:0] y_axis_o;
  logic [ByteW-1:0] face_buttons_o;
  logic [ByteW-1:0] system_buttons_o;
  logic [1:0]       link_state_o;
  logic             cfg_valid_i      = 1'b0;
  logic             cfg_ready_o;
  logic [ByteW-1:0] cfg_data_i       = '0;

  gamepad_report_link_controller_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .keys_i           (keys_i),
    .paired_i         (paired_i),
    .command_ready_i  (command_ready_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .x_axis_o         (x_axis_o),
    .y_axis_o         (y_axis_o),
    .face_buttons_o   (face_buttons_o),
    .system_buttons_o (system_buttons_o),
    .link_state_o     (link_state_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's link, hold counter, last report and
  // threshold register. Advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  link_e            link_now      = LINK_DISCOVERING;
  logic [ByteW-1:0] start_frames  = '0;
  report_t          last_sent     = '0;
  logic [ByteW-1:0] threshold_now = HoldThresholdRst;

  frame_t      frames_to_send[$];
  result_t     link_results[$];
  int unsigned frames_queued = 0;
  int unsigned error_count   = 0;

  // Pressure controls, written by the stimulus process at the falling edge
  bit          sender_hold     = 1'b0;
  int unsigned long_stall_reqs = 0;

  function automatic result_t next_link_result(logic [KeyW-1:0] k, logic pair, logic cmd);
    result_t r;
    report_t fresh;
    logic    drop;
    r    = '0;
    drop = 1'b0;
    case (link_now)
      LINK_DISCOVERING: begin
        // A press wins over a paired host
        if (k[KeyA]) begin
          if (cmd) begin
            link_now = LINK_CONNECTING;
            r.act    = ACT_CONNECT;
          end else begin
            r.act = ACT_FAILED;
          end
        end else if (pair) begin
          link_now = LINK_CONNECTED;
        end
      end
      LINK_CONNECTING: begin
        if (pair) link_now = LINK_CONNECTED;
      end
      LINK_CONNECTED: begin
        // Saturating start counter; fires only when it steps onto the threshold
        if (k[KeyStart]) begin
          if (start_frames != HoldMax) begin
            start_frames = start_frames + 1'b1;
            drop         = (start_frames == threshold_now);
          end
        end else begin
          start_frames = '0;
        end
        if (drop) begin
          link_now = LINK_DISCOVERING;
          r.act    = ACT_DISCONNECT;
        end else begin
          fresh = '0;
          if (k[KeyA])      fresh.face[0] = 1'b1;
          if (k[KeyB])      fresh.face[1] = 1'b1;
          if (k[KeyL])      fresh.face[4] = 1'b1;
          if (k[KeyR])      fresh.face[5] = 1'b1;
          if (k[KeySelect]) fresh.sys[4]  = 1'b1;
          if (k[KeyStart])  fresh.sys[5]  = 1'b1;
          // later assignment wins: down over up, left over right
          if (k[KeyUp])     fresh.y_axis  = AxisNeg;
          if (k[KeyDown])   fresh.y_axis  = AxisPos;
          if (k[KeyRight])  fresh.x_axis  = AxisPos;
          if (k[KeyLeft])   fresh.x_axis  = AxisNeg;
          if (fresh != last_sent) begin
            last_sent = fresh;
            r.rep     = fresh;
            r.act     = ACT_REPORT;
          end
        end
      end
      default: ;
    endcase
    r.link = link_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. The payload only moves
  // once the current beat is taken, so a stalled beat stays put.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  frame_t      next_frame;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (frames_to_send.size() == 0 || sender_hold) begin
        in_valid_i <= 1'b0;
      end else begin
        next_frame      = frames_to_send.pop_front();
        keys_i          <= next_frame.keys;
        paired_i        <= next_frame.paired;
        command_ready_i <= next_frame.cmd_ready;
        in_valid_i      <= 1'b1;
        if (burst_left <= 1) begin
          // a third of the bursts run straight into the next one
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between free, light, heavy and periodic.
  // A long hold-off is served on request and counted here.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode           = RX_FREE;
  int unsigned rx_mode_left      = 0;
  int unsigned rx_tick           = 0;
  int unsigned long_stall_served = 0;
  int unsigned long_stall_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (long_stall_served != long_stall_reqs) begin
        long_stall_served <= long_stall_reqs;
        long_stall_left   <= LongStallCycles;
        out_stall_i       <= 1'b1;
      end else if (long_stall_left != 0) begin
        long_stall_left <= long_stall_left - 1;
        out_stall_i     <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= rx_mode_e'($urandom_range(0, 3));
          rx_mode_left <= $urandom_range(20, 200);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          RX_FREE:     out_stall_i <= 1'b0;
          RX_LIGHT:    out_stall_i <= ($urandom_range(0, 9) < 3);
          RX_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: out_stall_i <= ((rx_tick % 5) < 2);
          default:     out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted input beat, then checks every accepted
  // result beat against the oldest prediction. Prediction comes first so the
  // store of results is only touched from this process.
  // ---------------------------------------------------------------------------
  result_t want_result;

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        link_results.push_back(next_link_result(keys_i, paired_i, command_ready_i));
      if (out_valid_o && !out_stall_i) begin
        if (link_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          error_count++;
        end else begin
          want_result = link_results.pop_front();
          check_field("action", 8'(want_result.act), 8'(action_o));
          check_field("x_axis", want_result.rep.x_axis, x_axis_o);
          check_field("y_axis", want_result.rep.y_axis, y_axis_o);
          check_field("face_buttons", want_result.rep.face, face_buttons_o);
          check_field("system_buttons", want_result.rep.sys, system_buttons_o);
          check_field("link_state", 8'(want_result.link), 8'(link_state_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All run from the falling edge, away from the driver.
  // ---------------------------------------------------------------------------
  task automatic queue_frame(input logic [KeyW-1:0] k, input logic pr, input logic cr);
    frames_to_send.push_back('{keys: k, paired: pr, cmd_ready: cr});
    frames_queued++;
  endtask

  // Wait until nothing is pending or in flight, then let the pipe settle
  task automatic drain_link();
    while (frames_to_send.size() != 0 || in_valid_i || link_results.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [ByteW-1:0] thr);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold_now = thr;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // One well-formed session: reach connected, play, then hold start for a
  // length often picked around the threshold. Rarely holds long enough to saturate.
  task automatic queue_session(input logic [ByteW-1:0] thr, inout bit sat_left);
    logic [KeyW-1:0] k;
    int unsigned     n;
    int unsigned     hold;
    int unsigned     pick;
    if ($urandom_range(0, 1) == 1) begin
      // connect attempt, maybe after a few failures
      repeat ($urandom_range(0, 2)) queue_frame(KeyW'($urandom()) | MaskA, 1'($urandom()), 1'b0);
      queue_frame(KeyW'($urandom()) | MaskA, 1'($urandom()), 1'b1);
      repeat ($urandom_range(0, 3)) queue_frame(KeyW'($urandom()), 1'b0, 1'($urandom()));
      queue_frame(KeyW'($urandom()), 1'b1, 1'($urandom()));
    end else begin
      // host pairs on its own
      repeat ($urandom_range(0, 2)) queue_frame(KeyW'($urandom()) & ~MaskA, 1'b0, 1'($urandom()));
      queue_frame(KeyW'($urandom()) & ~MaskA, 1'b1, 1'($urandom()));
    end
    // play: repeated keys check that unchanged reports stay quiet
    n = $urandom_range(2, 15);
    k = KeyW'($urandom()) & ~MaskStart;
    repeat (n) begin
      if ($urandom_range(0, 2) != 0) k = KeyW'($urandom());
      if ($urandom_range(0, 4) != 0) k = k & ~MaskStart;
      queue_frame(k, 1'($urandom()), 1'($urandom()));
    end
    pick = $urandom_range(0, 9);
    if (pick == 9 && sat_left) begin
      hold     = $urandom_range(256, 300);
      sat_left = 1'b0;
    end else if (pick >= 4 && pick <= 7 && thr != 0) begin
      hold = int'(thr) - 1 + $urandom_range(0, 3);
    end else if (pick == 8) begin
      hold = $urandom_range(0, 40);
    end else begin
      hold = $urandom_range(0, 4);
    end
    repeat (hold) begin
      if ($urandom_range(0, 3) == 0) k = KeyW'($urandom());
      queue_frame(k | MaskStart, 1'($urandom()), 1'($urandom()));
    end
    if ($urandom_range(0, 2) != 0) queue_frame(k & ~MaskStart, 1'($urandom()), 1'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] phase_thr;
  int unsigned      phase_idx;
  int unsigned      phase_start;
  bit               sat_left;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset threshold 150, link discovering
    queue_frame('0, 1'b0, 1'b0);                         // nothing happens
    queue_frame(MaskA, 1'b1, 1'b0);                      // connect refused
    queue_frame(MaskAll, 1'b0, 1'b1);                    // connect attempt
    queue_frame(MaskAll, 1'b0, 1'b1);                    // still connecting
    queue_frame(MaskA, 1'b1, 1'b0);                      // host paired
    queue_frame('0, 1'b0, 1'b0);                         // all-zero report stays quiet
    queue_frame(MaskRight, 1'b0, 1'b0);
    queue_frame(MaskRight, 1'b1, 1'b1);                  // unchanged report
    queue_frame(MaskRight | MaskLeft, 1'b0, 1'b0);       // left wins
    queue_frame(MaskUp, 1'b0, 1'b0);
    queue_frame(MaskUp | MaskDown, 1'b0, 1'b0);          // down wins
    queue_frame(MaskA | MaskB | MaskL | MaskR | MaskSelect, 1'b0, 1'b0);
    queue_frame(MaskAll, 1'b1, 1'b1);                    // start counted once
    queue_frame('0, 1'b0, 1'b0);                         // release clears count
    drain_link();

    // Threshold 1: first start frame disconnects, no report on that frame
    write_threshold(8'd1);
    queue_frame(MaskStart, 1'b0, 1'b0);
    // counter survives the disconnect: reconnect and it is already past 1
    queue_frame(MaskStart, 1'b1, 1'b1);
    queue_frame(MaskStart, 1'b0, 1'b0);
    drain_link();

    // Zero threshold: start held while connected never disconnects
    write_threshold(8'd0);
    queue_frame(MaskStart | MaskDown, 1'b0, 1'b0);
    queue_frame(MaskStart, 1'b0, 1'b0);
    queue_frame(MaskStart, 1'b1, 1'b1);
    drain_link();

    // Random phases: fixed extremes first, then random thresholds
    phase_idx   = 0;
    phase_start = frames_queued;
    while (frames_queued - phase_start < RandomFrames) begin
      case (phase_idx)
        0:       phase_thr = HoldThresholdRst;
        1:       phase_thr = 8'd1;
        2:       phase_thr = 8'd255;
        3:       phase_thr = 8'd0;
        4:       phase_thr = 8'd2;
        default: phase_thr = ($urandom_range(0, 3) == 0) ? ByteW'($urandom_range(41, 254))
                                                         : ByteW'($urandom_range(3, 40));
      endcase
      write_threshold(phase_thr);
      sat_left = 1'b1;
      begin : fill_phase
        int unsigned phase_base;
        phase_base = frames_queued;
        while (frames_queued - phase_base < ((phase_idx == 0) ? 2 * PhaseFrames : PhaseFrames)) begin
          if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4))
              queue_frame(KeyW'($urandom()), 1'($urandom()), 1'($urandom()));
          queue_session(phase_thr, sat_left);
        end
      end
      if (phase_idx == 0) begin
        // Long receiver hold-off while the sender keeps offering beats: the
        // block fills up and stalls its input.
        long_stall_reqs++;
        while (frames_to_send.size() > 60) @(negedge clk_i);
        // Sender pause with work left: everything in flight must drain first
        sender_hold = 1'b1;
        while (link_results.size() != 0 || in_valid_i) @(negedge clk_i);
        repeat (5) @(negedge clk_i);
        sender_hold = 1'b0;
      end
      drain_link();
      phase_idx++;
    end

    drain_link();
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/grlc_pkg.sv
rtl/core/grlc_report_build.sv
rtl/core/grlc_link_fsm.sv
rtl/core/gamepad_report_link_controller_top.sv
tb/gamepad_report_link_controller_top_tb.sv
